// ===== sv/blamka_pkg.sv =====
// Package for the BLAMKA block compression: sizes, state encoding and the
// index schedule of permutation P. No dependencies.
`default_nettype none
package blamka_pkg;

    localparam int WordW  = 64;
    localparam int Words  = 128;
    localparam int Pairs  = 64;
    localparam int AddrW  = 7;
    localparam int PairW  = 6;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD,
        ST_MIX,
        ST_WR,
        ST_OUT_RD,
        ST_OUT
    } state_t;

    typedef logic [AddrW-1:0] addr_t;

    // Quad of word indices for mix number m (0..127): 8 column rounds of 8
    // mixes, then 8 strided rounds of 8 mixes.
    function automatic logic [4*AddrW-1:0] quad_idx(input logic [6:0] m);
        logic [6:0] a, b, c, d;
        logic [6:0] base;
        logic [2:0] j;
        j = m[2:0];
        if (!m[6])
        begin
            base = {m[5:3], 4'd0};
            case (j)
                3'd0: begin a = 7'd0; b = 7'd4; c = 7'd8;  d = 7'd12; end
                3'd1: begin a = 7'd1; b = 7'd5; c = 7'd9;  d = 7'd13; end
                3'd2: begin a = 7'd2; b = 7'd6; c = 7'd10; d = 7'd14; end
                3'd3: begin a = 7'd3; b = 7'd7; c = 7'd11; d = 7'd15; end
                3'd4: begin a = 7'd0; b = 7'd5; c = 7'd10; d = 7'd15; end
                3'd5: begin a = 7'd1; b = 7'd6; c = 7'd11; d = 7'd12; end
                3'd6: begin a = 7'd2; b = 7'd7; c = 7'd8;  d = 7'd13; end
                default: begin a = 7'd3; b = 7'd4; c = 7'd9; d = 7'd14; end
            endcase
        end
        else
        begin
            base = {3'd0, m[5:3], 1'b0};
            case (j)
                3'd0: begin a = 7'd0;  b = 7'd32; c = 7'd64; d = 7'd96;  end
                3'd1: begin a = 7'd1;  b = 7'd33; c = 7'd65; d = 7'd97;  end
                3'd2: begin a = 7'd16; b = 7'd48; c = 7'd80; d = 7'd112; end
                3'd3: begin a = 7'd17; b = 7'd49; c = 7'd81; d = 7'd113; end
                3'd4: begin a = 7'd0;  b = 7'd33; c = 7'd80; d = 7'd113; end
                3'd5: begin a = 7'd1;  b = 7'd48; c = 7'd81; d = 7'd96;  end
                3'd6: begin a = 7'd16; b = 7'd49; c = 7'd64; d = 7'd97;  end
                default: begin a = 7'd17; b = 7'd32; c = 7'd65; d = 7'd112; end
            endcase
        end
        return {a + base, b + base, c + base, d + base};
    endfunction

endpackage
`default_nettype wire

// ===== sv/blamka_g_unit.sv =====
// Shared BLAMKA G unit: one full G (two half-steps of multiply-add, xor,
// rotate) per call on four registered words. Uses blamka_pkg.
`default_nettype none
module blamka_g_unit
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [blamka_pkg::WordW-1:0]  a_in,
    input  wire logic [blamka_pkg::WordW-1:0]  b_in,
    input  wire logic [blamka_pkg::WordW-1:0]  c_in,
    input  wire logic [blamka_pkg::WordW-1:0]  d_in,
    output logic                               done,
    output logic [blamka_pkg::WordW-1:0]       a_out,
    output logic [blamka_pkg::WordW-1:0]       b_out,
    output logic [blamka_pkg::WordW-1:0]       c_out,
    output logic [blamka_pkg::WordW-1:0]       d_out
);
    localparam int W = blamka_pkg::WordW;

    // step: 0 a+=b, 1 d=rot(d^a), 2 c+=d, 3 b=rot(b^c), ... 8 phases
    logic [3:0]   step_reg, step_next;
    logic         busy_reg, busy_next;
    logic [W-1:0] a_reg, b_reg, c_reg, d_reg;
    logic [W-1:0] a_next, b_next, c_next, d_next;
    logic [W-1:0] prod_reg, prod_next;
    logic         half_reg, half_next;
    logic [W-1:0] x_op, y_op, sum, xr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            half_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            half_reg <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        d_reg    <= d_next;
        prod_reg <= prod_next;
    end

    always_comb
    begin
        x_op = step_reg[1] ? c_reg : a_reg;
        y_op = step_reg[1] ? d_reg : b_reg;
        sum  = x_op + y_op + {prod_reg[W-2:0], 1'b0};
        xr   = '0;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; d_next = d_reg;
        prod_next = {32'd0, x_op[31:0]} * {32'd0, y_op[31:0]};
        step_next = step_reg;
        busy_next = busy_reg;
        half_next = half_reg;
        done = 1'b0;
        if (start && !busy_reg)
        begin
            a_next = a_in; b_next = b_in; c_next = c_in; d_next = d_in;
            busy_next = 1'b1;
            step_next = '0;
            half_next = 1'b0;
        end
        else if (busy_reg)
        begin
            // each add registers the product first, then forms the sum
            if (!step_reg[0] && !half_reg)
                half_next = 1'b1;
            else
            begin
                half_next = 1'b0;
                step_next = step_reg + 4'd1;
                case (step_reg[1:0])
                    2'd0: a_next = sum;
                    2'd1:
                    begin
                        xr = d_reg ^ a_reg;
                        d_next = step_reg[2] ? {xr[15:0], xr[63:16]}
                                             : {xr[31:0], xr[63:32]};
                    end
                    2'd2: c_next = sum;
                    default:
                    begin
                        xr = b_reg ^ c_reg;
                        b_next = step_reg[2] ? {xr[62:0], xr[63]}
                                             : {xr[23:0], xr[63:24]};
                    end
                endcase
                if (step_reg == 4'd7)
                begin
                    busy_next = 1'b0;
                    done = 1'b1;
                end
            end
        end
    end

    assign a_out = a_next;
    assign b_out = b_next;
    assign c_out = c_next;
    assign d_out = d_next;
endmodule
`default_nettype wire

// ===== sv/blamka_block_compression.sv =====
// BLAMKA block compression (Argon2 G) top level.
// Uses blamka_pkg and blamka_g_unit.
//
// Usage: send 64 input items, each two consecutive words of the previous,
// reference and old blocks; mix_old is taken from the first item of a block.
// Items 0..62 are taken one per cycle and give no result. After item 63 the
// block stalls its input and runs permutation P: 128 G calls on one shared
// G unit; each call reads its four words one at a time, runs the G
// arithmetic and writes the four words back one at a time.
// Then 64 result items (out_even, out_odd, final_pair on the last) leave, one
// pair at a time while out_stall is low; a stall holds the item.
// Reset clears the load count, mix flag and control; memories are not
// cleared since every word is written while loading.
// The next block is taken only after the last result item has left.
`default_nettype none
module blamka_block_compression
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] prev_even,
    input  wire logic [63:0] prev_odd,
    input  wire logic [63:0] ref_even,
    input  wire logic [63:0] ref_odd,
    input  wire logic [63:0] old_even,
    input  wire logic [63:0] old_odd,
    input  wire logic        mix_old,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      out_even,
    output logic [63:0]      out_odd,
    output logic             final_pair
);
    localparam int W = blamka_pkg::WordW;
    localparam int AW = blamka_pkg::AddrW;

    logic [W-1:0] work_mem [blamka_pkg::Words];
    logic [W-1:0] feed_mem [blamka_pkg::Words];

    blamka_pkg::state_t state_reg, state_next;
    logic [5:0]   load_reg, load_next;
    logic         mix_reg, mix_next;
    logic [6:0]   call_reg, call_next;
    logic [2:0]   sub_reg, sub_next;
    logic [5:0]   pair_reg, pair_next;
    logic         ovalid_reg, ovalid_next;
    logic [W-1:0] w_reg [4];
    logic [W-1:0] rdata_reg, fdata_reg;
    logic [W-1:0] oe_reg, oo_reg;
    logic         ofinal_reg;
    logic [4*AW-1:0] quad;
    logic [AW-1:0] raddr, waddr;
    logic         we;
    logic [W-1:0] wdata;
    logic         g_start, g_done;
    logic [W-1:0] ga, gb, gc, gd;
    logic [W-1:0] ga_q, gb_q, gc_q, gd_q;
    logic         in_acc;
    logic [W-1:0] r0, r1;

    assign quad = blamka_pkg::quad_idx(call_reg);
    assign in_acc = in_valid && !in_stall;
    assign r0 = prev_even ^ ref_even;
    assign r1 = prev_odd ^ ref_odd;

    blamka_g_unit u_g
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (g_start),
        .a_in  (w_reg[0]),
        .b_in  (w_reg[1]),
        .c_in  (w_reg[2]),
        .d_in  (w_reg[3]),
        .done  (g_done),
        .a_out (ga),
        .b_out (gb),
        .c_out (gc),
        .d_out (gd)
    );

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            work_mem[{load_reg, 1'b0}] <= r0;
            work_mem[{load_reg, 1'b1}] <= r1;
            feed_mem[{load_reg, 1'b0}] <= (load_reg == '0 ? mix_old : mix_reg)
                                          ? r0 ^ old_even : r0;
            feed_mem[{load_reg, 1'b1}] <= (load_reg == '0 ? mix_old : mix_reg)
                                          ? r1 ^ old_odd : r1;
        end
        else if (we)
            work_mem[waddr] <= wdata;
        rdata_reg <= work_mem[raddr];
        fdata_reg <= feed_mem[raddr];
        // sub 4 wraps the index to 3 for word d
        if (state_reg == blamka_pkg::ST_RD && sub_reg != 3'd0)
            w_reg[sub_reg[1:0] - 2'd1] <= rdata_reg;
        if (g_done)
        begin
            ga_q <= ga; gb_q <= gb; gc_q <= gc; gd_q <= gd;
        end
        if (state_reg == blamka_pkg::ST_OUT_RD && sub_reg == 3'd1)
            oe_reg <= rdata_reg ^ fdata_reg;
        if (state_reg == blamka_pkg::ST_OUT_RD && sub_reg == 3'd2)
        begin
            oo_reg     <= rdata_reg ^ fdata_reg;
            ofinal_reg <= pair_reg[5:0] == 6'd63;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= blamka_pkg::ST_LOAD;
            load_reg   <= '0;
            mix_reg    <= 1'b0;
            call_reg   <= '0;
            sub_reg    <= '0;
            pair_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            load_reg   <= load_next;
            mix_reg    <= mix_next;
            call_reg   <= call_next;
            sub_reg    <= sub_next;
            pair_reg   <= pair_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        load_next   = load_reg;
        mix_next    = mix_reg;
        call_next   = call_reg;
        sub_next    = sub_reg;
        pair_next   = pair_reg;
        ovalid_next = ovalid_reg;
        in_stall    = 1'b1;
        raddr       = '0;
        waddr       = '0;
        we          = 1'b0;
        wdata       = ga_q;
        g_start     = 1'b0;
        case (state_reg)
            blamka_pkg::ST_LOAD:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (load_reg == '0)
                        mix_next = mix_old;
                    load_next = load_reg + 6'd1;
                    if (load_reg == 6'd63)
                    begin
                        state_next = blamka_pkg::ST_RD;
                        call_next  = '0;
                        sub_next   = '0;
                    end
                end
            end
            blamka_pkg::ST_RD:
            begin
                // sub 0..3 issue reads a,b,c,d; data lands in the next cycle
                case (sub_reg[1:0])
                    2'd0: raddr = quad[4*AW-1:3*AW];
                    2'd1: raddr = quad[3*AW-1:2*AW];
                    2'd2: raddr = quad[2*AW-1:AW];
                    default: raddr = quad[AW-1:0];
                endcase
                sub_next = sub_reg + 3'd1;
                if (sub_reg == 3'd4)
                begin
                    state_next = blamka_pkg::ST_MIX;
                    sub_next   = '0;
                end
            end
            blamka_pkg::ST_MIX:
            begin
                g_start = (sub_reg == 3'd0);
                sub_next = 3'd1;
                if (g_done)
                begin
                    state_next = blamka_pkg::ST_WR;
                    sub_next   = '0;
                end
            end
            blamka_pkg::ST_WR:
            begin
                we = 1'b1;
                case (sub_reg[1:0])
                    2'd0: begin waddr = quad[4*AW-1:3*AW]; wdata = ga_q; end
                    2'd1: begin waddr = quad[3*AW-1:2*AW]; wdata = gb_q; end
                    2'd2: begin waddr = quad[2*AW-1:AW];   wdata = gc_q; end
                    default: begin waddr = quad[AW-1:0];   wdata = gd_q; end
                endcase
                sub_next = sub_reg + 3'd1;
                if (sub_reg == 3'd3)
                begin
                    sub_next  = '0;
                    call_next = call_reg + 7'd1;
                    if (call_reg == 7'd127)
                    begin
                        state_next = blamka_pkg::ST_OUT_RD;
                        pair_next  = '0;
                    end
                    else
                        state_next = blamka_pkg::ST_RD;
                end
            end
            blamka_pkg::ST_OUT_RD:
            begin
                raddr = {pair_reg[5:0], sub_reg[0]};
                sub_next = sub_reg + 3'd1;
                if (sub_reg == 3'd2)
                begin
                    sub_next    = '0;
                    ovalid_next = 1'b1;
                    state_next  = blamka_pkg::ST_OUT;
                end
            end
            blamka_pkg::ST_OUT:
            begin
                if (!out_stall)
                begin
                    ovalid_next = 1'b0;
                    pair_next   = pair_reg + 6'd1;
                    state_next  = (pair_reg[5:0] == 6'd63) ? blamka_pkg::ST_LOAD
                                                           : blamka_pkg::ST_OUT_RD;
                end
            end
            default: state_next = blamka_pkg::ST_LOAD;
        endcase
    end

    assign out_valid  = ovalid_reg;
    assign out_even   = oe_reg;
    assign out_odd    = oo_reg;
    assign final_pair = ofinal_reg;
endmodule
`default_nettype wire
